// ===== hdl/ntc_pkg.sv =====
// ---------------------------------------------------------------------------
// ntc_pkg: shared types and constants for the NTC thermistor reader
// Holds the controller/datapath command and status types.
// ---------------------------------------------------------------------------
package ntc_pkg;

  localparam int SampleW   = 12;
  localparam int SumW      = 16;
  localparam int CntW      = 4;
  localparam int NumRegs   = 8;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 17;

  localparam logic [SampleW-1:0] AdcFullScale = 12'd4095;
  localparam logic [SampleW-1:0] RailMargin   = 12'd5;

  localparam logic [CfgIdxW-1:0] REG_BETA = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_R0   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GMIN = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GMAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OKL  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OKH  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_WL   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_WH   = 3'd7;

  localparam logic [1:0] BAND_OK   = 2'd0;
  localparam logic [1:0] BAND_WARN = 2'd1;
  localparam logic [1:0] BAND_CRIT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_LOG_A,
    ST_LOAD_B,
    ST_LOG_B,
    ST_DEN,
    ST_NUM,
    ST_DIV_T,
    ST_TEMP,
    ST_DIV_G,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accum;     // add sample to sum
    logic load_a;    // start log of numerator
    logic load_b;    // start log of denominator
    logic log_step;  // one squaring step
    logic calc_den;
    logic calc_num;  // also start divider
    logic div_step;
    logic calc_temp; // also start gauge divider
    logic finish;
    logic out_pop;
  } cmd_t;

  typedef struct packed {
    logic done16;    // this sample closes a reading
    logic invalid;   // average near a rail
    logic log_done;
    logic den_bad;   // beta denominator nonpositive
    logic div_done;
    logic gauge_div; // gauge needs a division
  } sts_t;

endpackage

// ===== hdl/ntc_ctrl.sv =====
// ---------------------------------------------------------------------------
// ntc_ctrl: conversion sequencer
// Steps the datapath through averaging, two logs, Beta division and gauge.
// ---------------------------------------------------------------------------
module ntc_ctrl
  import ntc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_fire,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_full
);

  state_t state_r, state_nxt;
  logic   out_full_r;
  logic   out_free;

  // output register can take a new word this cycle
  assign out_free = !out_full_r || out_fire;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire && sts.done16) state_nxt = ST_LOAD_A;
      ST_LOAD_A: state_nxt = sts.invalid ? ST_FINISH : ST_LOG_A;
      ST_LOG_A:  if (sts.log_done) state_nxt = ST_LOAD_B;
      ST_LOAD_B: state_nxt = ST_LOG_B;
      ST_LOG_B:  if (sts.log_done) state_nxt = ST_DEN;
      ST_DEN:    state_nxt = ST_NUM;
      ST_NUM:    state_nxt = sts.den_bad ? ST_TEMP : ST_DIV_T;
      ST_DIV_T:  if (sts.div_done) state_nxt = ST_TEMP;
      ST_TEMP:   state_nxt = ST_DIV_G;
      ST_DIV_G:  if (!sts.gauge_div || sts.div_done) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.accum = in_fire;
    cmd.out_pop = out_fire;
    unique case (state_r)
      ST_LOAD_A: cmd.load_a = 1'b1;
      ST_LOG_A:  cmd.log_step = 1'b1;
      ST_LOAD_B: cmd.load_b = 1'b1;
      ST_LOG_B:  cmd.log_step = 1'b1;
      ST_DEN:    cmd.calc_den = 1'b1;
      ST_NUM:    cmd.calc_num = 1'b1;
      ST_DIV_T:  cmd.div_step = 1'b1;
      ST_TEMP:   cmd.calc_temp = 1'b1;
      ST_DIV_G:  cmd.div_step = sts.gauge_div;
      ST_FINISH: cmd.finish = out_free;
      default:   ;
    endcase
  end

  assign busy     = (state_r != ST_IDLE);
  assign out_full = out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_full_r <= 1'b0;
    else if (cmd.finish) out_full_r <= 1'b1;
    else if (out_fire)   out_full_r <= 1'b0;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire) else $error("input taken while converting");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_full && !out_fire |=> out_full) else $error("result dropped");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) && in_fire && sts.done16 |=> state_r == ST_LOAD_A)
    else $error("conversion did not start");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_full_r || out_fire)) else $error("result overwritten");

endmodule

// ===== hdl/ntc_datapath.sv =====
// ---------------------------------------------------------------------------
// ntc_datapath: accumulator, Q16 log unit, serial divider and result logic
// Executes one controller command per cycle.
// ---------------------------------------------------------------------------
module ntc_datapath
  import ntc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic [SampleW-1:0]   sample,
  input  logic [13:0]          beta,
  input  logic [16:0]          r0,
  input  logic signed [11:0]   gmin,
  input  logic signed [11:0]   gmax,
  input  logic signed [11:0]   okl,
  input  logic signed [11:0]   okh,
  input  logic signed [11:0]   wl,
  input  logic signed [11:0]   wh,
  output sts_t                 sts,
  output logic [23:0]          result
);

  logic [SumW-1:0] sum_r;
  logic [CntW-1:0] cnt_r;
  logic [SampleW-1:0] avg_r;
  logic [SumW-1:0] sum_add;

  assign sum_add = sum_r + SumW'(sample);
  assign sts.done16 = (cnt_r == {CntW{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.accum) begin
      cnt_r <= cnt_r + 1'b1;
      sum_r <= sts.done16 ? '0 : sum_add;
      if (sts.done16) avg_r <= sum_add[SumW-1 -: SampleW];
    end
  end

  assign sts.invalid = (avg_r <= RailMargin) || (avg_r >= AdcFullScale - RailMargin);

  // log unit: m in Q30 (31 bits held, top < 2^32 after square)
  logic [31:0] m_r;
  logic [5:0]  e_r;
  logic [15:0] frac_r;
  logic [4:0]  lstep_r;
  logic [63:0] sq;
  logic [33:0] m_sq;
  logic [35:0] lx;
  logic [5:0]  lz;
  logic [63:0] lxs;
  logic [21:0] log2q;
  logic [53:0] lnprod;
  logic [21:0] lnv;
  logic [21:0] ln_a_r;
  logic signed [22:0] l_r;

  always_comb begin
    lx = cmd.load_a ? 36'(avg_r) * 36'd10000
                    : 36'(AdcFullScale - avg_r) * 36'(r0 == '0 ? 17'd1 : r0);
    lz = '0;
    for (int i = 0; i < 36; i++) if (lx[i]) lz = 6'(i);
  end
  assign lxs = (lz >= 6'd30) ? 64'(lx >> (lz - 6'd30)) : 64'(lx) << (6'd30 - lz);

  assign sq   = m_r * m_r;
  assign m_sq = sq[63:30];
  assign sts.log_done = (lstep_r == 5'd16);
  assign log2q  = {e_r, frac_r};
  assign lnprod = 54'(log2q) * 54'd2977044472 + 54'h80000000;
  assign lnv    = lnprod[53:32];

  always_ff @(posedge clk) begin
    if (cmd.load_a || cmd.load_b) begin
      m_r <= lxs[31:0];
      e_r <= lz;
      frac_r <= '0;
      lstep_r <= '0;
    end else if (cmd.log_step && !sts.log_done) begin
      lstep_r <= lstep_r + 1'b1;
      if (m_sq[33:31] != 3'd0) begin
        m_r <= m_sq[32:1];
        frac_r <= {frac_r[14:0], 1'b1};
      end else begin
        m_r <= m_sq[31:0];
        frac_r <= {frac_r[14:0], 1'b0};
      end
    end
    if (cmd.load_b) ln_a_r <= lnv;
    if (cmd.log_step && sts.log_done)
      l_r <= $signed({1'b0, ln_a_r}) - $signed({1'b0, lnv});
  end

  // Beta equation and shared restoring divider
  logic signed [40:0] d_r;
  logic [51:0] dvd_r;
  logic [40:0] dvs_r;
  logic [51:0] quo_r;
  logic [48:0] rem_r;
  logic [5:0]  dcnt_r;
  logic [5:0]  dlen_r;
  logic signed [40:0] d_calc;
  logic [48:0] rem_sh;
  logic [51:0] n_calc;

  assign d_calc = 41'(beta) * 41'd6553600 + 41'(l_r) * 41'sd29315;
  assign sts.den_bad = (d_r <= 0);
  assign n_calc = 52'(beta) * 52'd192118784000 + 52'(d_r[40:1]);
  assign rem_sh = {rem_r[47:0], dvd_r[51]};
  assign sts.div_done = (dcnt_r == dlen_r);

  logic signed [19:0] th_r;
  logic signed [12:0] tt;
  logic signed [19:0] th_abs5;
  logic [39:0] tq_prod;
  logic [19:0] tq;
  logic signed [19:0] g0, gden_raw, gd;
  logic signed [26:0] gnum_raw, gn;
  logic [27:0] gdvd;
  logic [6:0] gpct_r;
  logic use_div_r, gdiv_r;

  always_ff @(posedge clk) begin
    if (cmd.calc_den) d_r <= d_calc;
    if (cmd.calc_num) begin
      dvd_r <= n_calc; dvs_r <= d_r; rem_r <= '0; quo_r <= '0;
      dcnt_r <= '0; dlen_r <= 6'd52;
    end else if (cmd.calc_temp) begin
      dvd_r <= {gdvd, 24'd0};
      dvs_r <= 41'(gd) << 1;
      rem_r <= '0; quo_r <= '0; dcnt_r <= '0; dlen_r <= 6'd28;
    end else if (cmd.div_step && !sts.div_done) begin
      dcnt_r <= dcnt_r + 1'b1;
      dvd_r <= dvd_r << 1;
      if (rem_sh >= 49'(dvs_r)) begin
        rem_r <= rem_sh - 49'(dvs_r);
        quo_r <= {quo_r[50:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[50:0], 1'b0};
      end
    end
  end

  // temperature in hundredths C, taken at gauge setup; clip the hot end at
  // 400000, which leaves temperature, gauge and band unchanged
  logic signed [19:0] th_now;
  assign th_now = (sts.den_bad || quo_r >= 52'd427315) ? 20'sd400000
                : $signed(quo_r[19:0]) - 20'sd27315;

  assign g0       = th_now - 20'(gmin) * 20'sd10;
  assign gden_raw = (20'(gmax) - 20'(gmin)) * 20'sd10;
  assign gnum_raw = 27'(g0) * 27'sd100;
  assign gn  = (gden_raw < 0) ? -gnum_raw : gnum_raw;
  assign gd  = (gden_raw < 0) ? -gden_raw : gden_raw;
  // 2*num+den over 2*den: dividend placed in top bits
  always_ff @(posedge clk) begin
    if (cmd.calc_temp) begin
      th_r <= th_now;
      if (gden_raw == 0) begin
        gdiv_r <= 1'b0; gpct_r <= (g0 >= 0) ? 7'd100 : 7'd0;
      end else if (gn <= 0) begin
        gdiv_r <= 1'b0; gpct_r <= 7'd0;
      end else if (34'(gn) >= 34'(gd) * 34'd100) begin
        gdiv_r <= 1'b0; gpct_r <= 7'd100;
      end else begin
        gdiv_r <= 1'b1; gpct_r <= '0;
      end
    end
  end
  assign use_div_r = gdiv_r;
  assign sts.gauge_div = use_div_r;

  // the gauge dividend is (2*gn+gd) in 28 bits, left aligned in the dividend register
  assign gdvd = 28'(2 * 34'(gn) + 34'(gd));

  // divide |th|+5 by ten with a reciprocal multiply, exact below 2^22
  assign th_abs5 = (th_r < 0) ? (-th_r + 20'sd5) : (th_r + 20'sd5);
  assign tq_prod = 40'(th_abs5[18:0]) * 40'd838861;
  assign tq = 20'(tq_prod[39:23]);

  always_comb begin
    if (th_r < 0) tt = (tq > 20'd2730) ? -13'sd2730 : -13'(tq);
    else          tt = (tq > 20'd4000) ? 13'sd4000 : 13'(tq);
  end

  logic [1:0] bnd;
  always_comb begin
    if (th_r >= 20'(okl) * 20'sd10 && th_r <= 20'(okh) * 20'sd10) bnd = BAND_OK;
    else if (th_r >= 20'(wl) * 20'sd10 && th_r <= 20'(wh) * 20'sd10) bnd = BAND_WARN;
    else bnd = BAND_CRIT;
  end

  logic [23:0] res_r;
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (sts.invalid) res_r <= {1'b0, 1'b0, BAND_CRIT, 7'd0, 13'd0};
      else res_r <= {1'b0, 1'b1, bnd, (gdiv_r ? quo_r[6:0] : gpct_r), tt};
    end
  end
  assign result = res_r;

endmodule

// ===== hdl/ntc_thermistor_temperature_reader_top.sv =====
// ---------------------------------------------------------------------------
// ntc_thermistor_temperature_reader_top
// Averages 16 ADC words and converts each average to temperature, gauge and band.
// ---------------------------------------------------------------------------
//  channel | direction | word contents
//  in_     | slave     | tdata[11:0] adc_sample
//  out_    | master    | tdata[12:0] temp, [19:13] gauge, [21:20] band, [22] valid
//  cfg_    | write     | index 0..7, data up to 17 bits
//
// The 16th sample word starts a conversion of at most two 16-step log squarings
// and 52 + 28 divider steps; a clamped gauge skips its 28 steps, and a rail
// reading goes straight to the finish step.
// Input stays not ready during a conversion only; a result waiting in the
// output register holds the next conversion in its last step, not the input.
// Reset (rst_n low, synchronous) clears sum and count and restores the configuration registers.
module ntc_thermistor_temperature_reader_top
  import ntc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] adc_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [12:0] temperature_tenths, [19:13] gauge_percent,
                                  // [21:20] band_status, [22] reading_valid
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic busy, out_full, in_fire, out_fire;
  logic [23:0] result;

  logic [13:0] beta_r;
  logic [16:0] r0_r;
  logic signed [11:0] gmin_r, gmax_r, okl_r, okh_r, wl_r, wh_r;

  // hold registers; write one per enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beta_r <= 14'd3950; r0_r <= 17'd1287;
      gmin_r <= 12'sd150; gmax_r <= 12'sd350;
      okl_r <= 12'sd240;  okh_r <= 12'sd300;
      wl_r <= 12'sd200;   wh_r <= 12'sd330;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BETA: beta_r <= cfg_data[13:0];
        REG_R0:   r0_r   <= cfg_data;
        REG_GMIN: gmin_r <= cfg_data[11:0];
        REG_GMAX: gmax_r <= cfg_data[11:0];
        REG_OKL:  okl_r  <= cfg_data[11:0];
        REG_OKH:  okh_r  <= cfg_data[11:0];
        REG_WL:   wl_r   <= cfg_data[11:0];
        REG_WH:   wh_r   <= cfg_data[11:0];
        default:  ;
      endcase
    end
  end

  assign in_tready  = !busy;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_full;
  assign out_fire   = out_tvalid && out_tready;
  assign out_tdata  = result;

  ntc_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .cmd, .busy, .out_full
  );

  ntc_datapath u_dp (
    .clk, .rst_n, .cmd, .sample(in_tdata[11:0]),
    .beta(beta_r), .r0(r0_r), .gmin(gmin_r), .gmax(gmax_r),
    .okl(okl_r), .okh(okh_r), .wl(wl_r), .wh(wh_r),
    .sts, .result
  );

endmodule
